### sv/spct_pkg.sv
// Package for the shape pair collision test: fixed-point widths, pipeline depths,
// pair kind codes and the record carried through the square root and divide stages.
// No dependencies.
package spct_pkg;

    localparam int FRAC_BITS  = 12;
    localparam int POS_W      = 24;
    localparam int SIZE_W     = 23;
    localparam int DSQ_W      = 50;
    localparam int DIST_W     = 24;
    localparam int NORM_W     = 16;

    localparam int DIFF_W     = POS_W + 2;
    localparam int ABS_W      = POS_W + 1;
    localparam int SQ_W       = 2 * ABS_W;
    localparam int SUM_W      = SQ_W + 2;
    localparam int THR_W      = 2 * DIST_W;
    localparam int OVL_W      = ABS_W + 2;
    localparam int HDSQ_W     = THR_W;
    localparam int SQ_IN_W    = HDSQ_W + FRAC_BITS;
    localparam int ROOT_W     = SQ_IN_W / 2;
    localparam int REM_W      = ROOT_W + 3;
    localparam int NORM_SHIFT = 14 + FRAC_BITS / 2;
    localparam int QUO_W      = 15;
    localparam int NUM_W      = ROOT_W + QUO_W;

    localparam int SQ_BITS    = 2;
    localparam int SQ_STAGES  = ROOT_W / SQ_BITS;
    localparam int DV_BITS    = 3;
    localparam int DV_STAGES  = QUO_W / DV_BITS;

    localparam logic [NORM_W-1:0] NORM_ONE     = NORM_W'(16384);
    localparam logic [NORM_W-1:0] NORM_NEG_ONE = NORM_W'(-16384);

    typedef enum logic [1:0] {
        CMD_SPHERE      = 2'd0,
        CMD_CIRCLE      = 2'd1,
        CMD_RECT_CIRCLE = 2'd2,
        CMD_RECT_RECT   = 2'd3
    } t_cmd;

    typedef struct packed {
        logic                         hit;
        logic                         is_rect;
        logic [HDSQ_W-1:0]            dsq;
        logic [DIST_W-1:0]            mind;
        logic [2:0][DIST_W-1:0]       mag;
        logic [2:0]                   neg;
        logic [NORM_W-1:0]            rnx;
        logic [NORM_W-1:0]            rny;
    } t_lane;

endpackage

### sv/spct_in_if.sv
// Input channel of the shape pair collision test: one shape pair per transaction.
// Depends on spct_pkg.
interface spct_in_if;
    import spct_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [1:0]               cmd;
    logic signed [POS_W-1:0]  a_x;
    logic signed [POS_W-1:0]  a_y;
    logic signed [POS_W-1:0]  a_z;
    logic signed [POS_W-1:0]  b_x;
    logic signed [POS_W-1:0]  b_y;
    logic signed [POS_W-1:0]  b_z;
    logic [SIZE_W-1:0]        a_size_x;
    logic [SIZE_W-1:0]        a_size_y;
    logic [SIZE_W-1:0]        b_size_x;
    logic [SIZE_W-1:0]        b_size_y;

    modport source (output valid, cmd, a_x, a_y, a_z, b_x, b_y, b_z,
                    a_size_x, a_size_y, b_size_x, b_size_y, input ready);
    modport sink (input valid, cmd, a_x, a_y, a_z, b_x, b_y, b_z,
                  a_size_x, a_size_y, b_size_x, b_size_y, output ready);
endinterface

### sv/spct_out_if.sv
// Result channel of the shape pair collision test: one result per transaction.
// Depends on spct_pkg.
interface spct_out_if;
    import spct_pkg::*;

    logic                     valid;
    logic                     ready;
    logic                     hit;
    logic [DSQ_W-1:0]         dist_sq;
    logic [DIST_W-1:0]        min_dist;
    logic signed [NORM_W-1:0] normal_x;
    logic signed [NORM_W-1:0] normal_y;
    logic signed [NORM_W-1:0] normal_z;

    modport source (output valid, hit, dist_sq, min_dist, normal_x, normal_y, normal_z,
                    input ready);
    modport sink (input valid, hit, dist_sq, min_dist, normal_x, normal_y, normal_z,
                  output ready);
endinterface

### sv/shape_pair_collision_test.sv
// The block takes one shape pair per cycle while the output side does not stall, and
// returns one result per pair, in order.
// A pair passes through 28 register stages: six of difference, square and compare work,
// fifteen square root stages resolving two root bits each, one divide setup stage, five
// divide stages that give three normal bits each, and the output register.
// Every stage has its own valid bit, so bubbles close up under back pressure.
// Depends on spct_pkg, spct_in_if and spct_out_if.
module shape_pair_collision_test (
    input  logic        i_clk,
    input  logic        i_rst_n,
    spct_in_if.sink     i_pair,
    spct_out_if.source  o_res
);
    import spct_pkg::*;

    localparam int ST_SQ0 = 6;
    localparam int ST_DV0 = ST_SQ0 + SQ_STAGES;
    localparam int ST_OUT = ST_DV0 + DV_STAGES + 1;
    localparam int NST    = ST_OUT + 1;

    logic [NST-1:0] r_v;
    logic [NST-1:0] w_en;

    always_comb begin
        w_en[NST-1] = !r_v[NST-1] || o_res.ready;
        for (int k = NST - 2; k >= 0; k--) begin
            w_en[k] = !r_v[k] || w_en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_en[0]) begin
                r_v[0] <= i_pair.valid;
            end
            for (int k = 1; k < NST; k++) begin
                if (w_en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    assign i_pair.ready = w_en[0];

    // Stage 1: bounds and plain differences.
    logic signed [ABS_W-1:0] w_ax, w_ay, w_az, w_bx, w_by, w_bz, w_asx, w_asy;
    t_cmd                    r1_cmd;
    logic signed [ABS_W-1:0] r1_lo_x, r1_hi_x, r1_lo_y, r1_hi_y;
    logic signed [POS_W-1:0] r1_bx, r1_by;
    logic signed [ABS_W-1:0] r1_d0x, r1_d0y, r1_d0z;
    logic [DIST_W-1:0]       r1_sumx, r1_sumy, r1_mind;

    assign w_ax  = ABS_W'(i_pair.a_x);
    assign w_ay  = ABS_W'(i_pair.a_y);
    assign w_az  = ABS_W'(i_pair.a_z);
    assign w_bx  = ABS_W'(i_pair.b_x);
    assign w_by  = ABS_W'(i_pair.b_y);
    assign w_bz  = ABS_W'(i_pair.b_z);
    assign w_asx = $signed({2'b00, i_pair.a_size_x});
    assign w_asy = $signed({2'b00, i_pair.a_size_y});

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r1_cmd  <= t_cmd'(i_pair.cmd);
            r1_lo_x <= w_ax - w_asx;
            r1_hi_x <= w_ax + w_asx;
            r1_lo_y <= w_ay - w_asy;
            r1_hi_y <= w_ay + w_asy;
            r1_bx   <= i_pair.b_x;
            r1_by   <= i_pair.b_y;
            r1_d0x  <= w_bx - w_ax;
            r1_d0y  <= w_by - w_ay;
            r1_d0z  <= w_bz - w_az;
            r1_sumx <= DIST_W'(i_pair.a_size_x) + DIST_W'(i_pair.b_size_x);
            r1_sumy <= DIST_W'(i_pair.a_size_y) + DIST_W'(i_pair.b_size_y);
            if (t_cmd'(i_pair.cmd) == CMD_RECT_CIRCLE) begin
                r1_mind <= DIST_W'(i_pair.b_size_x);
            end else begin
                r1_mind <= DIST_W'(i_pair.a_size_x) + DIST_W'(i_pair.b_size_x);
            end
        end
    end

    // Stage 2: clamp against the rectangle and select the delta per pair kind.
    logic signed [DIFF_W-1:0] w_cbx, w_cby, w_clx, w_chx, w_cly, w_chy;
    logic signed [DIFF_W-1:0] w_cdx, w_cdy, w_dx, w_dy, w_dz;
    t_cmd                     r2_cmd;
    logic signed [DIFF_W-1:0] r2_dx, r2_dy, r2_dz;
    logic [DIST_W-1:0]        r2_sumx, r2_sumy, r2_mind;

    assign w_cbx = DIFF_W'(r1_bx);
    assign w_cby = DIFF_W'(r1_by);
    assign w_clx = DIFF_W'(r1_lo_x);
    assign w_chx = DIFF_W'(r1_hi_x);
    assign w_cly = DIFF_W'(r1_lo_y);
    assign w_chy = DIFF_W'(r1_hi_y);

    always_comb begin
        if (w_cbx < w_clx) begin
            w_cdx = w_cbx - w_clx;
        end else if (w_cbx > w_chx) begin
            w_cdx = w_cbx - w_chx;
        end else begin
            w_cdx = '0;
        end
        if (w_cby < w_cly) begin
            w_cdy = w_cby - w_cly;
        end else if (w_cby > w_chy) begin
            w_cdy = w_cby - w_chy;
        end else begin
            w_cdy = '0;
        end
        unique case (r1_cmd)
            CMD_SPHERE: begin
                w_dx = DIFF_W'(r1_d0x);
                w_dy = DIFF_W'(r1_d0y);
                w_dz = DIFF_W'(r1_d0z);
            end
            CMD_RECT_CIRCLE: begin
                w_dx = w_cdx;
                w_dy = w_cdy;
                w_dz = '0;
            end
            default: begin
                w_dx = DIFF_W'(r1_d0x);
                w_dy = DIFF_W'(r1_d0y);
                w_dz = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r2_cmd  <= r1_cmd;
            r2_dx   <= w_dx;
            r2_dy   <= w_dy;
            r2_dz   <= w_dz;
            r2_sumx <= r1_sumx;
            r2_sumy <= r1_sumy;
            r2_mind <= r1_mind;
        end
    end

    // Stage 3: magnitudes and signs.
    logic signed [DIFF_W-1:0] w_ndx, w_ndy, w_ndz;
    t_cmd                     r3_cmd;
    logic [2:0][ABS_W-1:0]    r3_abs;
    logic [2:0]               r3_neg;
    logic [DIST_W-1:0]        r3_sumx, r3_sumy, r3_mind;

    assign w_ndx = -r2_dx;
    assign w_ndy = -r2_dy;
    assign w_ndz = -r2_dz;

    always_ff @(posedge i_clk) begin
        if (w_en[2]) begin
            r3_cmd    <= r2_cmd;
            r3_abs[0] <= r2_dx[DIFF_W-1] ? w_ndx[ABS_W-1:0] : r2_dx[ABS_W-1:0];
            r3_abs[1] <= r2_dy[DIFF_W-1] ? w_ndy[ABS_W-1:0] : r2_dy[ABS_W-1:0];
            r3_abs[2] <= r2_dz[DIFF_W-1] ? w_ndz[ABS_W-1:0] : r2_dz[ABS_W-1:0];
            r3_neg    <= {r2_dz[DIFF_W-1], r2_dy[DIFF_W-1], r2_dx[DIFF_W-1]};
            r3_sumx   <= r2_sumx;
            r3_sumy   <= r2_sumy;
            r3_mind   <= r2_mind;
        end
    end

    // Stage 4: squares, threshold and rectangle overlaps.
    t_cmd                     r4_cmd;
    logic [SQ_W-1:0]          r4_sqx, r4_sqy, r4_sqz;
    logic [THR_W-1:0]         r4_thr;
    logic signed [OVL_W-1:0]  r4_ox, r4_oy;
    logic [2:0][ABS_W-1:0]    r4_abs;
    logic [2:0]               r4_neg;
    logic [DIST_W-1:0]        r4_mind;

    always_ff @(posedge i_clk) begin
        if (w_en[3]) begin
            r4_cmd  <= r3_cmd;
            r4_sqx  <= r3_abs[0] * r3_abs[0];
            r4_sqy  <= r3_abs[1] * r3_abs[1];
            r4_sqz  <= r3_abs[2] * r3_abs[2];
            r4_thr  <= r3_mind * r3_mind;
            r4_ox   <= $signed({3'b000, r3_sumx}) - $signed({2'b00, r3_abs[0]});
            r4_oy   <= $signed({3'b000, r3_sumy}) - $signed({2'b00, r3_abs[1]});
            r4_abs  <= r3_abs;
            r4_neg  <= r3_neg;
            r4_mind <= r3_mind;
        end
    end

    // Stage 5: squared distance and rectangle decision.
    t_cmd                     r5_cmd;
    logic [SUM_W-1:0]         r5_dsq;
    logic [THR_W-1:0]         r5_thr;
    logic                     r5_rhit, r5_selx;
    logic [2:0][ABS_W-1:0]    r5_abs;
    logic [2:0]               r5_neg;
    logic [DIST_W-1:0]        r5_mind;

    always_ff @(posedge i_clk) begin
        if (w_en[4]) begin
            r5_cmd  <= r4_cmd;
            r5_dsq  <= SUM_W'(r4_sqx) + SUM_W'(r4_sqy) + SUM_W'(r4_sqz);
            r5_thr  <= r4_thr;
            r5_rhit <= (r4_ox > 0) && (r4_oy > 0);
            r5_selx <= r4_ox < r4_oy;
            r5_abs  <= r4_abs;
            r5_neg  <= r4_neg;
            r5_mind <= r4_mind;
        end
    end

    // Stage 6: hit decision and the record for the normal path.
    logic  w_rect, w_hit, w_round;
    t_lane w_lane;
    t_lane r6_lane;

    assign w_rect  = r5_cmd == CMD_RECT_RECT;
    assign w_hit   = w_rect ? r5_rhit : (r5_dsq < SUM_W'(r5_thr));
    assign w_round = w_hit && !w_rect;

    always_comb begin
        w_lane         = '0;
        w_lane.hit     = w_hit;
        w_lane.is_rect = w_rect;
        w_lane.neg     = r5_neg;
        if (w_round) begin
            w_lane.dsq  = r5_dsq[HDSQ_W-1:0];
            w_lane.mind = r5_mind;
            for (int i = 0; i < 3; i++) begin
                w_lane.mag[i] = r5_abs[i][DIST_W-1:0];
            end
        end
        if (w_hit && w_rect) begin
            if (r5_selx) begin
                if (r5_neg[0]) begin
                    w_lane.rnx = NORM_NEG_ONE;
                end else if (r5_abs[0] != '0) begin
                    w_lane.rnx = NORM_ONE;
                end
            end else begin
                if (r5_neg[1]) begin
                    w_lane.rny = NORM_NEG_ONE;
                end else if (r5_abs[1] != '0) begin
                    w_lane.rny = NORM_ONE;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[5]) begin
            r6_lane <= w_lane;
        end
    end

    // Square root of dsq scaled by the fraction bits, two root bits per stage.
    t_lane              r_sq_ln   [SQ_STAGES];
    logic [REM_W-1:0]   r_sq_rem  [SQ_STAGES];
    logic [ROOT_W-1:0]  r_sq_root [SQ_STAGES];

    for (genvar s = 0; s < SQ_STAGES; s++) begin : g_sq
        t_lane              w_in;
        logic [REM_W-1:0]   w_rem_in;
        logic [ROOT_W-1:0]  w_root_in;
        logic [SQ_IN_W-1:0] w_x;
        logic [REM_W-1:0]   w_rem;
        logic [REM_W-1:0]   w_trial;
        logic [ROOT_W-1:0]  w_root;

        if (s == 0) begin : g_first
            assign w_in      = r6_lane;
            assign w_rem_in  = '0;
            assign w_root_in = '0;
        end else begin : g_next
            assign w_in      = r_sq_ln[s-1];
            assign w_rem_in  = r_sq_rem[s-1];
            assign w_root_in = r_sq_root[s-1];
        end

        assign w_x = {w_in.dsq, FRAC_BITS'(0)};

        always_comb begin
            w_rem  = w_rem_in;
            w_root = w_root_in;
            w_trial = '0;
            for (int t = 0; t < SQ_BITS; t++) begin
                w_rem   = {w_rem[REM_W-3:0], w_x[SQ_IN_W-1-2*(s*SQ_BITS+t) -: 2]};
                w_trial = {1'b0, w_root, 2'b01};
                if (w_rem >= w_trial) begin
                    w_rem  = w_rem - w_trial;
                    w_root = {w_root[ROOT_W-2:0], 1'b1};
                end else begin
                    w_root = {w_root[ROOT_W-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en[ST_SQ0+s]) begin
                r_sq_ln[s]   <= w_in;
                r_sq_rem[s]  <= w_rem;
                r_sq_root[s] <= w_root;
            end
        end
    end

    // Normal division: magnitude scaled up, plus half the length, over the length.
    t_lane                   r_dv_ln  [DV_STAGES+1];
    logic [ROOT_W-1:0]       r_dv_len [DV_STAGES+1];
    logic [2:0][NUM_W-1:0]   r_dv_num [DV_STAGES+1];
    logic [2:0][ROOT_W-1:0]  r_dv_rem [DV_STAGES+1];
    logic [2:0][QUO_W-1:0]   r_dv_q   [DV_STAGES+1];
    logic [2:0][NUM_W-1:0]   w_num0;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_num0[i] = (NUM_W'(r_sq_ln[SQ_STAGES-1].mag[i]) << NORM_SHIFT)
                        + NUM_W'(r_sq_root[SQ_STAGES-1] >> 1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[ST_DV0]) begin
            r_dv_ln[0]  <= r_sq_ln[SQ_STAGES-1];
            r_dv_len[0] <= r_sq_root[SQ_STAGES-1];
            r_dv_num[0] <= w_num0;
            r_dv_q[0]   <= '0;
            for (int i = 0; i < 3; i++) begin
                r_dv_rem[0][i] <= w_num0[i][NUM_W-1 -: ROOT_W];
            end
        end
    end

    for (genvar d = 1; d <= DV_STAGES; d++) begin : g_dv
        logic [2:0][ROOT_W-1:0] w_rem;
        logic [2:0][QUO_W-1:0]  w_q;
        logic [ROOT_W:0]        w_tmp [3];

        always_comb begin
            for (int i = 0; i < 3; i++) begin
                w_rem[i] = r_dv_rem[d-1][i];
                w_q[i]   = r_dv_q[d-1][i];
                w_tmp[i] = '0;
                for (int t = 0; t < DV_BITS; t++) begin
                    w_tmp[i] = {w_rem[i],
                                r_dv_num[d-1][i][QUO_W-1-((d-1)*DV_BITS+t)]};
                    if (w_tmp[i] >= {1'b0, r_dv_len[d-1]}) begin
                        w_tmp[i] = w_tmp[i] - {1'b0, r_dv_len[d-1]};
                        w_q[i][QUO_W-1-((d-1)*DV_BITS+t)] = 1'b1;
                    end
                    w_rem[i] = w_tmp[i][ROOT_W-1:0];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en[ST_DV0+d]) begin
                r_dv_ln[d]  <= r_dv_ln[d-1];
                r_dv_len[d] <= r_dv_len[d-1];
                r_dv_num[d] <= r_dv_num[d-1];
                r_dv_rem[d] <= w_rem;
                r_dv_q[d]   <= w_q;
            end
        end
    end

    // Output register.
    t_lane                  w_fl;
    logic [2:0][NORM_W-1:0] w_nrm;
    logic [NORM_W-1:0]      w_mag [3];
    logic                   r_o_hit;
    logic [DSQ_W-1:0]       r_o_dsq;
    logic [DIST_W-1:0]      r_o_mind;
    logic [2:0][NORM_W-1:0] r_o_nrm;

    assign w_fl = r_dv_ln[DV_STAGES];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (r_dv_q[DV_STAGES][i] > QUO_W'(NORM_ONE)) begin
                w_mag[i] = NORM_ONE;
            end else begin
                w_mag[i] = NORM_W'(r_dv_q[DV_STAGES][i]);
            end
            if (!w_fl.hit || w_fl.is_rect || r_dv_len[DV_STAGES] == '0) begin
                w_nrm[i] = '0;
            end else if (w_fl.neg[i]) begin
                w_nrm[i] = -w_mag[i];
            end else begin
                w_nrm[i] = w_mag[i];
            end
        end
        if (w_fl.hit && w_fl.is_rect) begin
            w_nrm[0] = w_fl.rnx;
            w_nrm[1] = w_fl.rny;
            w_nrm[2] = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[ST_OUT]) begin
            r_o_hit  <= w_fl.hit;
            r_o_dsq  <= DSQ_W'(w_fl.dsq);
            r_o_mind <= w_fl.mind;
            r_o_nrm  <= w_nrm;
        end
    end

    assign o_res.valid    = r_v[ST_OUT];
    assign o_res.hit      = r_o_hit;
    assign o_res.dist_sq  = r_o_dsq;
    assign o_res.min_dist = r_o_mind;
    assign o_res.normal_x = r_o_nrm[0];
    assign o_res.normal_y = r_o_nrm[1];
    assign o_res.normal_z = r_o_nrm[2];

endmodule

### sim/spct_checker.sv
`timescale 1ns / 1ps
// Checker for the shape pair collision test: watches both channels, predicts each result
// and compares it field by field. Depends on spct_pkg, spct_in_if and spct_out_if.
module spct_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    spct_in_if   i_pair,
    spct_out_if  i_res,
    output int   o_errors,
    output int   o_pending
);
    import spct_pkg::*;

    typedef struct {
        logic              hit;
        logic [DSQ_W-1:0]  dist_sq;
        logic [DIST_W-1:0] min_dist;
        logic [NORM_W-1:0] nx;
        logic [NORM_W-1:0] ny;
        logic [NORM_W-1:0] nz;
    } t_collision;

    t_collision expected_q[$];

    function automatic longint unsigned int_sqrt(longint unsigned x);
        longint unsigned root;
        longint unsigned probe;
        root  = 0;
        probe = 64'd1 << 62;
        while (probe > x) probe = probe >> 2;
        while (probe != 0) begin
            if (x >= root + probe) begin
                x    = x - (root + probe);
                root = (root >> 1) + probe;
            end else begin
                root = root >> 1;
            end
            probe = probe >> 2;
        end
        return root;
    endfunction

    function automatic longint unsigned mag64(longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic logic [NORM_W-1:0] unit_comp(longint d, longint unsigned len);
        longint unsigned m;
        if (len == 0) return '0;
        m = ((mag64(d) << 20) + (len >> 1)) / len;
        if (m > 16384) m = 16384;
        return (d < 0) ? NORM_W'(-longint'(m)) : NORM_W'(m);
    endfunction

    function automatic logic [NORM_W-1:0] axis_sign(longint v);
        return (v > 0) ? NORM_ONE : ((v < 0) ? NORM_NEG_ONE : '0);
    endfunction

    function automatic longint clamp(longint v, longint lo, longint hi);
        if (v < lo) v = lo;
        if (v > hi) v = hi;
        return v;
    endfunction

    function automatic t_collision predict_collision();
        t_collision r;
        t_cmd kind;
        longint ax, ay, az, bx, by, bz, asx, asy, bsx, bsy;
        longint dx, dy, dz, ox, oy;
        longint unsigned dsq, mind, len;
        kind = t_cmd'(i_pair.cmd);
        ax = i_pair.a_x; ay = i_pair.a_y; az = i_pair.a_z;
        bx = i_pair.b_x; by = i_pair.b_y; bz = i_pair.b_z;
        asx = i_pair.a_size_x; asy = i_pair.a_size_y;
        bsx = i_pair.b_size_x; bsy = i_pair.b_size_y;
        r = '{default: '0};
        dz = 0;
        if (kind == CMD_RECT_RECT) begin
            dx = bx - ax;
            dy = by - ay;
            ox = asx + bsx - longint'(mag64(dx));
            oy = asy + bsy - longint'(mag64(dy));
            if (ox > 0 && oy > 0) begin
                r.hit = 1'b1;
                if (ox < oy) r.nx = axis_sign(dx);
                else r.ny = axis_sign(dy);
            end
        end else begin
            if (kind == CMD_RECT_CIRCLE) begin
                dx = bx - clamp(bx, ax - asx, ax + asx);
                dy = by - clamp(by, ay - asy, ay + asy);
                mind = bsx;
            end else begin
                dx = bx - ax;
                dy = by - ay;
                if (kind == CMD_SPHERE) dz = bz - az;
                mind = asx + bsx;
            end
            dsq = mag64(dx) * mag64(dx) + mag64(dy) * mag64(dy) + mag64(dz) * mag64(dz);
            if (dsq < mind * mind) begin
                len        = int_sqrt(dsq << 12);
                r.hit      = 1'b1;
                r.dist_sq  = DSQ_W'(dsq);
                r.min_dist = DIST_W'(mind);
                r.nx       = unit_comp(dx, len);
                r.ny       = unit_comp(dy, len);
                r.nz       = unit_comp(dz, len);
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(string field, longint got, longint want);
        $display("%0t: mismatch on %s: got %0h, expected %0h", $time, field, got, want);
        o_errors = o_errors + 1;
    endtask

    initial o_errors = 0;
    assign o_pending = expected_q.size();

    always @(posedge i_clk) begin
        t_collision want;
        if (i_rst_n) begin
            if (i_pair.valid && i_pair.ready) expected_q.push_back(predict_collision());
            if (i_res.valid && i_res.ready) begin
                if (expected_q.size() == 0) begin
                    $display("%0t: result transaction with no pair outstanding", $time);
                    o_errors = o_errors + 1;
                end else begin
                    want = expected_q.pop_front();
                    if (i_res.hit !== want.hit) report_mismatch("hit", i_res.hit, want.hit);
                    if (i_res.dist_sq !== want.dist_sq)
                        report_mismatch("dist_sq", i_res.dist_sq, want.dist_sq);
                    if (i_res.min_dist !== want.min_dist)
                        report_mismatch("min_dist", i_res.min_dist, want.min_dist);
                    if (i_res.normal_x !== want.nx)
                        report_mismatch("normal_x", i_res.normal_x, want.nx);
                    if (i_res.normal_y !== want.ny)
                        report_mismatch("normal_y", i_res.normal_y, want.ny);
                    if (i_res.normal_z !== want.nz)
                        report_mismatch("normal_z", i_res.normal_z, want.nz);
                end
            end
        end
    end
endmodule

### sim/shape_pair_collision_test_tb.sv
`timescale 1ns / 1ps
// Top of the shape pair collision test bench: clock, reset, pair stimulus, result stalls
// and the verdict. Depends on spct_pkg, both channel interfaces and spct_checker.
module shape_pair_collision_test_tb;
    import spct_pkg::*;

    localparam int RANDOM_PAIRS = 1750;
    localparam int CYCLE_LIMIT  = 600000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int   errors;
    int   pending;
    int   cycles = 0;
    int   stall_mode = 0;

    spct_in_if  pair_ch ();
    spct_out_if res_ch ();

    shape_pair_collision_test uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pair  (pair_ch),
        .o_res   (res_ch)
    );

    spct_checker u_checker (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_pair    (pair_ch),
        .i_res     (res_ch),
        .o_errors  (errors),
        .o_pending (pending)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Result side alternates between always ready, light stalls and heavy stalls.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
        end else begin
            if ($urandom_range(0, 199) == 0) stall_mode = $urandom_range(0, 2);
            case (stall_mode)
                0: res_ch.ready <= 1'b1;
                1: res_ch.ready <= ($urandom_range(0, 3) != 0);
                default: res_ch.ready <= ($urandom_range(0, 9) < 3);
            endcase
        end
    end

    task automatic send_pair(t_cmd kind, int ax, int ay, int az, int bx, int by, int bz,
                             int asx, int asy, int bsx, int bsy);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            pair_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        pair_ch.valid    <= 1'b1;
        pair_ch.cmd      <= kind;
        pair_ch.a_x      <= POS_W'(ax);
        pair_ch.a_y      <= POS_W'(ay);
        pair_ch.a_z      <= POS_W'(az);
        pair_ch.b_x      <= POS_W'(bx);
        pair_ch.b_y      <= POS_W'(by);
        pair_ch.b_z      <= POS_W'(bz);
        pair_ch.a_size_x <= SIZE_W'(asx);
        pair_ch.a_size_y <= SIZE_W'(asy);
        pair_ch.b_size_x <= SIZE_W'(bsx);
        pair_ch.b_size_y <= SIZE_W'(bsy);
        do @(negedge i_clk); while (!pair_ch.ready);
        @(posedge i_clk);
    endtask

    function automatic int near_offset(int mask);
        return $signed($urandom_range(0, 4 * mask + 2)) - 2 * mask - 1;
    endfunction

    task automatic send_random_pair();
        t_cmd kind;
        int   mask, ax, ay, az;
        kind = t_cmd'($urandom_range(0, 3));
        if ($urandom_range(0, 4) == 0) begin
            send_pair(kind, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                      $urandom, $urandom, $urandom, $urandom);
        end else begin
            mask = (1 << $urandom_range(0, 22)) - 1;
            ax = $urandom; ay = $urandom; az = $urandom;
            send_pair(kind, ax, ay, az, ax + near_offset(mask), ay + near_offset(mask),
                      az + near_offset(mask), $urandom & mask, $urandom & mask,
                      $urandom & mask, $urandom & mask);
        end
    endtask

    initial begin
        pair_ch.valid    = 1'b0;
        pair_ch.cmd      = CMD_SPHERE;
        pair_ch.a_x      = '0;
        pair_ch.a_y      = '0;
        pair_ch.a_z      = '0;
        pair_ch.b_x      = '0;
        pair_ch.b_y      = '0;
        pair_ch.b_z      = '0;
        pair_ch.a_size_x = '0;
        pair_ch.a_size_y = '0;
        pair_ch.b_size_x = '0;
        pair_ch.b_size_y = '0;
        res_ch.ready     = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Coincident centres give a zero normal; touching exactly is a miss.
        send_pair(CMD_SPHERE, 100, 200, 300, 100, 200, 300, 50, 0, 50, 0);
        send_pair(CMD_SPHERE, 0, 0, 0, 4096, 0, 0, 2048, 0, 2048, 0);
        send_pair(CMD_SPHERE, 0, 0, 0, 4095, -3000, 1000, 4096, 0, 4096, 0);
        send_pair(CMD_SPHERE, -8388608, -8388608, -8388608, 8388607, 8388607, 8388607,
                  8388607, 8388607, 8388607, 8388607);
        send_pair(CMD_SPHERE, 8388607, 0, -8388608, -8388608, 5, 8388607,
                  8388607, 0, 8388607, 0);
        send_pair(CMD_CIRCLE, 0, 0, 0, 3000, 4000, 999999, 3000, 0, 3000, 0);
        send_pair(CMD_CIRCLE, 0, 0, 0, 3000, 4000, 0, 2500, 0, 2500, 0);
        send_pair(CMD_CIRCLE, 10, 10, 0, 10, 10, 0, 0, 0, 0, 0);
        send_pair(CMD_CIRCLE, -8388608, 8388607, 0, 8388607, -8388608, 0,
                  8388607, 0, 8388607, 0);
        send_pair(CMD_RECT_CIRCLE, 0, 0, 0, 100, -50, 0, 1000, 1000, 10, 0);
        send_pair(CMD_RECT_CIRCLE, 0, 0, 0, 1500, 1200, 0, 1000, 1000, 600, 0);
        send_pair(CMD_RECT_CIRCLE, 0, 0, 0, -1500, 0, 0, 1000, 1000, 500, 0);
        send_pair(CMD_RECT_CIRCLE, 0, 0, 0, -1499, 0, 0, 1000, 1000, 500, 0);
        send_pair(CMD_RECT_CIRCLE, -8388608, -8388608, 0, 8388607, 8388607, 0,
                  8388607, 8388607, 8388607, 0);
        send_pair(CMD_RECT_RECT, 0, 0, 0, 100, 300, 0, 200, 200, 200, 200);
        send_pair(CMD_RECT_RECT, 0, 0, 0, -300, 100, 0, 200, 200, 200, 200);
        send_pair(CMD_RECT_RECT, 0, 0, 0, 100, 100, 0, 200, 200, 200, 200);
        send_pair(CMD_RECT_RECT, 0, 0, 0, 0, 0, 0, 200, 100, 200, 100);
        send_pair(CMD_RECT_RECT, 0, 0, 0, 400, 0, 0, 200, 200, 200, 200);
        send_pair(CMD_RECT_RECT, -8388608, 8388607, 0, 8388607, -8388608, 0,
                  8388607, 8388607, 8388607, 8388607);

        repeat (RANDOM_PAIRS) send_random_pair();
        pair_ch.valid <= 1'b0;
        @(posedge i_clk);

        while (pending != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule

### sim.f
sv/spct_pkg.sv
sv/spct_in_if.sv
sv/spct_out_if.sv
sv/shape_pair_collision_test.sv
sim/spct_checker.sv
sim/shape_pair_collision_test_tb.sv
